// ----- rtl/tsch_pkg.sv -----
// ----------------------------------------------------------------------------
// tsch_pkg
// Shared types and constants for the tilt side classifier with hysteresis.
// ----------------------------------------------------------------------------
package tsch_pkg;

	// Sample and register widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CORR_W   = SAMPLE_W + 1;
	localparam int unsigned DIFF_W   = CORR_W + 1;
	localparam int unsigned THRESH_W = 17;
	localparam int unsigned CFG_W    = 17;
	localparam int unsigned CFG_IDX_W = 2;

	// Register indexes on the write port
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD = 2'd2;

	// Threshold after reset: about 0.1 g at 8192 counts per g
	localparam logic [THRESH_W-1:0] HOLD_THRESHOLD_RST = 17'd819;

	// Downward side codes
	typedef enum logic [2:0] {
		SIDE_UNKNOWN = 3'd0,
		SIDE_FRONT   = 3'd1,
		SIDE_BACK    = 3'd2,
		SIDE_LEFT    = 3'd3,
		SIDE_RIGHT   = 3'd4
	} side_t;

	// Held orientation: side plus the corrected sample it was taken from
	typedef struct packed {
		side_t                     side;
		logic signed [CORR_W-1:0]  x;
		logic signed [CORR_W-1:0]  y;
		logic signed [CORR_W-1:0]  z;
	} held_t;

endpackage

// ----- rtl/tsch_classify.sv -----
// ----------------------------------------------------------------------------
// tsch_classify
// Offset correction, dominant axis side decision and the hysteresis test
// against the held orientation. Purely combinational.
// ----------------------------------------------------------------------------
module tsch_classify (
	input  logic signed [tsch_pkg::SAMPLE_W-1:0] accel_x,
	input  logic signed [tsch_pkg::SAMPLE_W-1:0] accel_y,
	input  logic signed [tsch_pkg::SAMPLE_W-1:0] accel_z,
	input  logic signed [tsch_pkg::SAMPLE_W-1:0] offset_x,
	input  logic signed [tsch_pkg::SAMPLE_W-1:0] offset_y,
	input  logic        [tsch_pkg::THRESH_W-1:0] hold_threshold,
	input  tsch_pkg::held_t                      held,
	output tsch_pkg::side_t                      side,
	output logic                                 update,
	output tsch_pkg::held_t                      held_next
);
	import tsch_pkg::*;

	logic signed [CORR_W-1:0] cx, cy, cz;
	logic        [CORR_W-1:0] ax, ay, az;
	logic signed [DIFF_W-1:0] dx, dy, dz;
	logic        [CORR_W-1:0] mx, my, mz;
	side_t                    new_side;
	logic                     hold;

	// Subtract offsets; Z is taken as it arrives
	assign cx = CORR_W'(accel_x) - CORR_W'(offset_x);
	assign cy = CORR_W'(accel_y) - CORR_W'(offset_y);
	assign cz = CORR_W'(accel_z);

	// Absolute values, all fit unsigned in CORR_W bits
	assign ax = cx[CORR_W-1] ? CORR_W'(-cx) : CORR_W'(cx);
	assign ay = cy[CORR_W-1] ? CORR_W'(-cy) : CORR_W'(cy);
	assign az = cz[CORR_W-1] ? CORR_W'(-cz) : CORR_W'(cz);

	// Pick the strictly dominant X or Y axis; a tie or a dominant Z gives SIDE_UNKNOWN
	always_comb begin
		priority if (ax > ay && ax > az) begin
			new_side = (!cx[CORR_W-1] && cx != '0) ? SIDE_FRONT : SIDE_BACK;
		end else if (ay > ax && ay > az) begin
			new_side = (!cy[CORR_W-1] && cy != '0) ? SIDE_LEFT : SIDE_RIGHT;
		end else begin
			new_side = SIDE_UNKNOWN;
		end
	end

	// Exact differences to the held sample and their magnitudes
	assign dx = DIFF_W'(cx) - DIFF_W'(held.x);
	assign dy = DIFF_W'(cy) - DIFF_W'(held.y);
	assign dz = DIFF_W'(cz) - DIFF_W'(held.z);
	assign mx = dx[DIFF_W-1] ? CORR_W'(-dx) : dx[CORR_W-1:0];
	assign my = dy[DIFF_W-1] ? CORR_W'(-dy) : dy[CORR_W-1:0];
	assign mz = dz[DIFF_W-1] ? CORR_W'(-dz) : dz[CORR_W-1:0];

	// Keep the held side only when both sides are known and nothing moved much
	assign hold = (held.side != SIDE_UNKNOWN) && (new_side != SIDE_UNKNOWN)
		&& (mx < hold_threshold) && (my < hold_threshold) && (mz < hold_threshold);

	assign update = !hold;
	assign side   = hold ? held.side : new_side;

	always_comb begin
		held_next.side = new_side;
		held_next.x    = cx;
		held_next.y    = cy;
		held_next.z    = cz;
	end

endmodule

// ----- rtl/tilt_side_classifier_hysteresis.sv -----
// ----------------------------------------------------------------------------
// tilt_side_classifier_hysteresis
// Classifies the downward side of a board from one accelerometer word and
// holds the previous side while the sample stays close to the held one.
// ----------------------------------------------------------------------------
// One word is accepted per clock cycle, sustained, as long as results are
// taken. An accepted word lands in the input register, is classified from it
// and is loaded into the result register when that register is empty or
// being drained. The rate is set by the single feedback loop through the
// held orientation register: offset subtract, absolute values, difference
// to the held sample and threshold compare. Configuration writes take effect
// at once and are meant to be made while no word is in flight.
// ----------------------------------------------------------------------------
module tilt_side_classifier_hysteresis (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 wr_en,
	input  logic [tsch_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [tsch_pkg::CFG_W-1:0]           wr_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [tsch_pkg::SAMPLE_W-1:0] accel_x,
	input  logic signed [tsch_pkg::SAMPLE_W-1:0] accel_y,
	input  logic signed [tsch_pkg::SAMPLE_W-1:0] accel_z,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [2:0]                           side
);
	import tsch_pkg::*;

	logic signed [SAMPLE_W-1:0] offset_x_q, offset_y_q;
	logic        [THRESH_W-1:0] hold_threshold_q;

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] x_s1, y_s1, z_s1;

	logic                       out_valid_q;
	side_t                      side_q;

	held_t                      held_q;
	held_t                      held_next;
	side_t                      calc_side;
	logic                       calc_update;

	logic                       out_load;
	logic                       advance;
	logic                       in_take;

	// Handshake: result register loads when empty or being drained
	assign out_load = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_load;
	assign in_stall = valid_s1 && !out_load;
	assign in_take  = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q       <= '0;
			offset_y_q       <= '0;
			hold_threshold_q <= HOLD_THRESHOLD_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_OFFSET_X:       offset_x_q       <= wr_data[SAMPLE_W-1:0];
				REG_OFFSET_Y:       offset_y_q       <= wr_data[SAMPLE_W-1:0];
				REG_HOLD_THRESHOLD: hold_threshold_q <= wr_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			x_s1 <= accel_x;
			y_s1 <= accel_y;
			z_s1 <= accel_z;
		end
	end

	tsch_classify u_classify (
		.accel_x        (x_s1),
		.accel_y        (y_s1),
		.accel_z        (z_s1),
		.offset_x       (offset_x_q),
		.offset_y       (offset_y_q),
		.hold_threshold (hold_threshold_q),
		.held           (held_q),
		.side           (calc_side),
		.update         (calc_update),
		.held_next      (held_next)
	);

	// Held orientation: replace unless the hysteresis test kept it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '{side: SIDE_UNKNOWN, x: '0, y: '0, z: '0};
		end else if (advance && calc_update) begin
			held_q <= held_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_q <= calc_side;
		end
	end

	assign out_valid = out_valid_q;
	assign side      = side_q;

endmodule

// ----- rtl/tsch_checker.sv -----
// ----------------------------------------------------------------------------
// tsch_checker
// Port level checks for the tilt side classifier, bound to the top level.
// ----------------------------------------------------------------------------
module tsch_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] side
);
	import tsch_pkg::*;

	// A stalled result word stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(side))
		else $error("result word changed while stalled");

	// Only defined side codes leave the block
	a_side_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> side <= SIDE_RIGHT)
		else $error("undefined side code");

	// Input stalls only when the result word is full and blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without back pressure");

	// A word taken behind a blocked result fills the input register
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && out_valid && out_stall |=> !out_stall || in_stall)
		else $error("input not stalled with both registers full");

endmodule

bind tilt_side_classifier_hysteresis tsch_checker u_tsch_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.side      (side)
);
